>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted
`define BCD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is asserted
`define BCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset
`define BCD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/bcd_pkg.sv
// ---------------------------------------------------------------------------
// bcd_pkg
// Types and constants of the button chord detector.
// ---------------------------------------------------------------------------
package bcd_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_BTN_W    = 32;
    localparam int TIME_W      = 64;
    localparam int TIMING_W    = 24;
    localparam int ENTRY_OUT_W = 2;
    // entries that own a mask register; those above have none and stay disabled
    localparam int MASK_REGS   = 4;

    localparam logic [TIMING_W-1:0] COOLDOWN_RESET = 24'd250000;
    localparam logic [TIMING_W-1:0] WINDOW_RESET   = 24'd500000;

    localparam logic ACT_PAUSE    = 1'b0;
    localparam logic ACT_KEYBOARD = 1'b1;

    // register map; mask register of entry e sits at index e
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHORD_MASK_PAUSE    = 3'd0,
        REG_CHORD_MASK_KEYBOARD = 3'd1,
        REG_CHORD_MASK_EXTRA_A  = 3'd2,
        REG_CHORD_MASK_EXTRA_B  = 3'd3,
        REG_EXTRA_A_ACTION      = 3'd4,
        REG_EXTRA_B_ACTION      = 3'd5,
        REG_COOLDOWN_US         = 3'd6,
        REG_WINDOW_US           = 3'd7
    } cfg_reg_t;

endpackage

>>> design/button_chord_detector_core.sv
// ---------------------------------------------------------------------------
// button_chord_detector_core
// Chord detector over pad samples with per-entry trackers and a cooldown.
// ---------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready carry one pad sample (s_buttons, s_now_us) per request.
//   m_valid/m_ready return exactly one result per sample: m_fired, and for a
//   firing the action and the entry index (both zero otherwise).
//   cfg_we/cfg_index/cfg_wdata write one register per cycle; write only when
//   the block is idle. Mask and action writes clear all trackers.
// Path: m_valid rises once the sample has passed the input register and then
//   the result register. Throughput: one sample per cycle while m_ready is
//   high; evaluating all entries combinationally with a priority pick sets
//   this figure, the trackers updating in the same cycle as the result.
// Reset: aresetn (synchronous, active low) empties both registers, clears
//   the trackers and the firing history, loads masks of zero, the fixed
//   actions and the default cooldown and window.
// Stall: while m_ready is low the result holds; one further sample is taken
//   into the input register, after which s_ready drops.
// ---------------------------------------------------------------------------
module button_chord_detector_core #(
    parameter int NUM_ENTRIES = 4,
    parameter int BUTTON_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bcd_pkg::IN_BTN_W-1:0]       s_buttons,
    input  logic [bcd_pkg::TIME_W-1:0]         s_now_us,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_fired,
    output logic                               m_fired_action,
    output logic [bcd_pkg::ENTRY_OUT_W-1:0]    m_fired_entry,
    input  logic                               cfg_we,
    input  logic [bcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bcd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int TW = bcd_pkg::TIME_W;

    // configuration
    logic [BUTTON_BITS-1:0]        mask_reg     [NUM_ENTRIES];
    logic                          action_reg   [NUM_ENTRIES];
    logic [bcd_pkg::TIMING_W-1:0]  cooldown_reg;
    logic [bcd_pkg::TIMING_W-1:0]  window_reg;
    logic                          cfg_clear;

    // trackers
    logic                          tracking_reg [NUM_ENTRIES];
    logic                          tracking_next[NUM_ENTRIES];
    logic                          waitrel_reg  [NUM_ENTRIES];
    logic                          waitrel_next [NUM_ENTRIES];
    logic [BUTTON_BITS-1:0]        seen_reg     [NUM_ENTRIES];
    logic [BUTTON_BITS-1:0]        seen_next    [NUM_ENTRIES];
    logic [TW-1:0]                 start_reg    [NUM_ENTRIES];
    logic                          start_load   [NUM_ENTRIES];
    logic [TW-1:0]                 last_fire_reg;
    logic                          fire_valid_reg;

    // pipeline
    logic                          in_vld_reg;
    logic [BUTTON_BITS-1:0]        in_btn_reg;
    logic [TW-1:0]                 in_now_reg;
    logic                          out_vld_reg;
    logic                          out_fired_reg;
    logic                          out_action_reg;
    logic [bcd_pkg::ENTRY_OUT_W-1:0] out_entry_reg;
    logic                          advance;
    logic                          process;

    // evaluation
    logic [TW-1:0]                 cool_diff;
    logic                          in_cooldown;
    logic                          hit;
    logic                          hit_action;
    logic [bcd_pkg::ENTRY_OUT_W-1:0] hit_entry;

    assign advance = !out_vld_reg || m_ready;
    assign process = in_vld_reg && advance;
    assign s_ready = !in_vld_reg || advance;

    assign m_valid        = out_vld_reg;
    assign m_fired        = out_fired_reg;
    assign m_fired_action = out_action_reg;
    assign m_fired_entry  = out_entry_reg;

    // mask and action writes that land on an existing entry clear the trackers
    always_comb begin
        cfg_clear = 1'b0;
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            if (cfg_we && e < bcd_pkg::MASK_REGS
                    && cfg_index == bcd_pkg::CFG_IDX_W'(e)) begin
                cfg_clear = 1'b1;
            end
            if (cfg_we && ((e == 2 && cfg_index == bcd_pkg::REG_EXTRA_A_ACTION)
                    || (e == 3 && cfg_index == bcd_pkg::REG_EXTRA_B_ACTION))) begin
                cfg_clear = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                mask_reg[e]   <= '0;
                action_reg[e] <= (e == 1) ? bcd_pkg::ACT_KEYBOARD : bcd_pkg::ACT_PAUSE;
            end
            cooldown_reg <= bcd_pkg::COOLDOWN_RESET;
            window_reg   <= bcd_pkg::WINDOW_RESET;
        end else if (cfg_we) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                if (e < bcd_pkg::MASK_REGS && cfg_index == bcd_pkg::CFG_IDX_W'(e)) begin
                    mask_reg[e] <= cfg_wdata[BUTTON_BITS-1:0];
                end
                if ((e == 2 && cfg_index == bcd_pkg::REG_EXTRA_A_ACTION)
                        || (e == 3 && cfg_index == bcd_pkg::REG_EXTRA_B_ACTION)) begin
                    action_reg[e] <= cfg_wdata[0];
                end
            end
            if (cfg_index == bcd_pkg::REG_COOLDOWN_US) begin
                cooldown_reg <= cfg_wdata[bcd_pkg::TIMING_W-1:0];
            end
            if (cfg_index == bcd_pkg::REG_WINDOW_US) begin
                window_reg <= cfg_wdata[bcd_pkg::TIMING_W-1:0];
            end
        end
    end

    // evaluate every entry in parallel; the first firing entry blocks the rest
    always_comb begin
        logic [BUTTON_BITS-1:0] p;
        logic [BUTTON_BITS-1:0] seen_or;
        logic [TW-1:0]          elapsed;
        logic                   fire_e;

        cool_diff   = in_now_reg - last_fire_reg;
        in_cooldown = fire_valid_reg
                      && cool_diff < {{(TW - bcd_pkg::TIMING_W){1'b0}}, cooldown_reg};
        hit         = 1'b0;
        hit_action  = bcd_pkg::ACT_PAUSE;
        hit_entry   = '0;

        for (int e = 0; e < NUM_ENTRIES; e++) begin
            p       = in_btn_reg & mask_reg[e];
            seen_or = seen_reg[e] | p;
            elapsed = in_now_reg - start_reg[e];
            fire_e  = 1'b0;

            tracking_next[e] = tracking_reg[e];
            waitrel_next[e]  = waitrel_reg[e];
            seen_next[e]     = seen_reg[e];
            start_load[e]    = 1'b0;

            if (!in_cooldown && !hit) begin
                if (mask_reg[e] == '0) begin
                    tracking_next[e] = 1'b0;
                    waitrel_next[e]  = 1'b0;
                    seen_next[e]     = '0;
                end else if (waitrel_reg[e]) begin
                    if (p == '0) begin
                        waitrel_next[e] = 1'b0;
                        seen_next[e]    = '0;
                    end
                end else if (!tracking_reg[e]) begin
                    if (p != '0) begin
                        tracking_next[e] = 1'b1;
                        seen_next[e]     = p;
                        start_load[e]    = 1'b1;
                    end
                end else if (elapsed > {{(TW - bcd_pkg::TIMING_W){1'b0}}, window_reg}
                             || p == '0) begin
                    // window expired or chord released: abort
                    tracking_next[e] = 1'b0;
                    seen_next[e]     = '0;
                end else if (seen_or == mask_reg[e] && p == mask_reg[e]) begin
                    tracking_next[e] = 1'b0;
                    waitrel_next[e]  = 1'b1;
                    seen_next[e]     = '0;
                    fire_e           = 1'b1;
                end else begin
                    seen_next[e] = seen_or;
                end
            end

            if (fire_e) begin
                hit        = 1'b1;
                hit_action = action_reg[e];
                hit_entry  = bcd_pkg::ENTRY_OUT_W'(e);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                tracking_reg[e] <= 1'b0;
                waitrel_reg[e]  <= 1'b0;
                seen_reg[e]     <= '0;
            end
            fire_valid_reg <= 1'b0;
            last_fire_reg  <= '0;
        end else if (cfg_clear) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                tracking_reg[e] <= 1'b0;
                waitrel_reg[e]  <= 1'b0;
                seen_reg[e]     <= '0;
            end
        end else if (process) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                tracking_reg[e] <= tracking_next[e];
                waitrel_reg[e]  <= waitrel_next[e];
                seen_reg[e]     <= seen_next[e];
            end
            if (hit) begin
                fire_valid_reg <= 1'b1;
                last_fire_reg  <= in_now_reg;
            end
        end
    end

    // start time is only read while tracking, and tracking always loads it
    always_ff @(posedge aclk) begin
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            if (process && start_load[e]) begin
                start_reg[e] <= in_now_reg;
            end
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (process) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_btn_reg <= s_buttons[BUTTON_BITS-1:0];
            in_now_reg <= s_now_us;
        end
    end

    // result register: advance whenever the receiver can take the next request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            out_fired_reg  <= hit;
            out_action_reg <= hit_action;
            out_entry_reg  <= hit_entry;
        end
    end

endmodule

>>> design/bcd_checker.sv
// ---------------------------------------------------------------------------
// bcd_checker
// Port-level checks of the button chord detector, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bcd_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic                               m_fired,
    input logic                               m_fired_action,
    input logic [bcd_pkg::ENTRY_OUT_W-1:0]    m_fired_entry
);

    // a stalled result holds
    `BCD_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_fired) && $stable(m_fired_action) && $stable(m_fired_entry))

    // a result without a firing carries zero fields
    `BCD_ASSERT_IMPL(a_idle_fields_zero, aclk, aresetn, m_valid && !m_fired, m_fired_action == bcd_pkg::ACT_PAUSE && m_fired_entry == 2'd0)

    // the two fixed entries report their fixed actions
    `BCD_ASSERT_IMPL(a_fixed_actions, aclk, aresetn, m_valid && m_fired && (m_fired_entry == 2'd0 || m_fired_entry == 2'd1), m_fired_action == ((m_fired_entry == 2'd1) ? bcd_pkg::ACT_KEYBOARD : bcd_pkg::ACT_PAUSE))

    // reset empties the result register
    `BCD_ASSERT_NEXT_ALWAYS(a_reset_empties, aclk, !aresetn, !m_valid)

endmodule

bind button_chord_detector_core bcd_checker u_bcd_checker (.*);
